[design/rrd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrd_pkg
// Types and constants shared by the RGBE run-length scanline decoder.
// ----------------------------------------------------------------------------
package rrd_pkg;

  // Parser phases
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SECOND,
    PH_WHI,
    PH_WLO,
    PH_COUNT,
    PH_RUNVAL,
    PH_LITERAL,
    PH_RAW
  } phase_t;

  // Error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_WIDTH = 2'd1;
  localparam logic [1:0] ERR_ZERO  = 2'd2;

  // Channel planes
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_EXP   = 2'd3;

  localparam logic [7:0] MARKER_BYTE = 8'd2;
  localparam logic [7:0] RUN_FLAG    = 8'd128;

  // One fill result
  typedef struct packed {
    logic [14:0] pixel_index;
    logic [1:0]  channel;
    logic [6:0]  fill_count;
    logic [7:0]  fill_value;
    logic        line_done;
    logic [1:0]  error_code;
  } fill_t;

  // Queue entry: one fill, optionally followed by the second opening raw byte
  typedef struct packed {
    fill_t      fill;
    logic       pair;
    logic [7:0] second_value;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

[design/rrd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrd_front
// Byte parser: tracks the scanline phase and turns bytes into fills where the phase calls for one.
// ----------------------------------------------------------------------------
module rrd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_accept,
  input  logic [7:0]         data_byte,
  input  logic               scan_start,
  input  logic               cfg_valid,
  input  logic [14:0]        cfg_data,
  output rrd_pkg::push_req_t push_req
);
  import rrd_pkg::*;

  phase_t      phase, phase_next;
  logic [14:0] scanline_width;
  logic [7:0]  held_first_byte, held_first_byte_next;
  logic [7:0]  width_high_byte, width_high_byte_next;
  logic [1:0]  current_channel, current_channel_next;
  logic [14:0] pixels_done, pixels_done_next;
  logic [6:0]  pending_run_length, pending_run_length_next;
  logic [7:0]  literal_remaining, literal_remaining_next;
  logic [16:0] flat_byte_index, flat_byte_index_next;

  logic [14:0] w;
  logic [17:0] flat_inc;
  logic        raw_done;
  logic        is_marker;
  logic        width_bad;
  logic        pd_over;
  logic [14:0] room;
  logic [6:0]  run_cnt;
  logic [15:0] pd_run;
  logic        run_full;
  logic        lit_room;
  logic [15:0] pd_lit;
  logic        lit_full;
  logic        lit_last;
  logic [7:0]  lit_dec;

  // Treat a zero width as one pixel
  assign w         = (scanline_width == 15'd0) ? 15'd1 : scanline_width;
  assign flat_inc  = {1'b0, flat_byte_index} + 18'd1;
  assign raw_done  = flat_inc >= {1'b0, w, 2'b00};
  assign is_marker = (held_first_byte == MARKER_BYTE) && (data_byte == MARKER_BYTE);
  assign width_bad = {width_high_byte, data_byte} != {1'b0, w};

  // Clamp runs to the room left in the plane
  assign pd_over  = pixels_done > w;
  assign room     = w - pixels_done;
  assign run_cnt  = (pd_over || ({8'd0, pending_run_length} < room)) ?
                    pending_run_length : room[6:0];
  assign pd_run   = {1'b0, pixels_done} + {9'd0, run_cnt};
  assign run_full = pd_run >= {1'b0, w};

  assign lit_room = pixels_done < w;
  assign pd_lit   = {1'b0, pixels_done} + 16'd1;
  assign lit_full = lit_room ? (pd_lit >= {1'b0, w}) : 1'b1;
  assign lit_dec  = literal_remaining - 8'd1;
  assign lit_last = lit_dec == 8'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_IDLE;
      scanline_width     <= 15'd1;
      held_first_byte    <= 8'd0;
      width_high_byte    <= 8'd0;
      current_channel    <= CH_RED;
      pixels_done        <= 15'd0;
      pending_run_length <= 7'd0;
      literal_remaining  <= 8'd0;
      flat_byte_index    <= 17'd0;
    end else begin
      phase              <= phase_next;
      held_first_byte    <= held_first_byte_next;
      width_high_byte    <= width_high_byte_next;
      current_channel    <= current_channel_next;
      pixels_done        <= pixels_done_next;
      pending_run_length <= pending_run_length_next;
      literal_remaining  <= literal_remaining_next;
      flat_byte_index    <= flat_byte_index_next;
      if (cfg_valid) begin
        scanline_width <= cfg_data;
      end
    end
  end

  // Next state
  always_comb begin
    phase_next              = phase;
    held_first_byte_next    = held_first_byte;
    width_high_byte_next    = width_high_byte;
    current_channel_next    = current_channel;
    pixels_done_next        = pixels_done;
    pending_run_length_next = pending_run_length;
    literal_remaining_next  = literal_remaining;
    flat_byte_index_next    = flat_byte_index;
    if (in_accept) begin
      if (scan_start) begin
        held_first_byte_next = data_byte;
        phase_next           = PH_SECOND;
      end else begin
        unique case (phase)
          PH_SECOND: begin
            if (is_marker) begin
              phase_next = PH_WHI;
            end else begin
              // both opening bytes go out at once
              flat_byte_index_next = 17'd2;
              phase_next           = PH_RAW;
            end
          end
          PH_RAW: begin
            flat_byte_index_next = flat_inc[16:0];
            if (raw_done) begin
              phase_next = PH_IDLE;
            end
          end
          PH_WHI: begin
            width_high_byte_next = data_byte;
            phase_next           = PH_WLO;
          end
          PH_WLO: begin
            if (width_bad) begin
              phase_next = PH_IDLE;
            end else begin
              current_channel_next = CH_RED;
              pixels_done_next     = 15'd0;
              phase_next           = PH_COUNT;
            end
          end
          PH_COUNT: begin
            if (data_byte > RUN_FLAG) begin
              pending_run_length_next = 7'(data_byte - RUN_FLAG);
              phase_next              = PH_RUNVAL;
            end else if (data_byte == 8'd0) begin
              phase_next = PH_IDLE;
            end else begin
              literal_remaining_next = data_byte;
              phase_next             = PH_LITERAL;
            end
          end
          PH_RUNVAL: begin
            pixels_done_next = pd_run[14:0];
            if (run_full) begin
              if (current_channel == CH_EXP) begin
                phase_next = PH_IDLE;
              end else begin
                current_channel_next = current_channel + 2'd1;
                pixels_done_next     = 15'd0;
                phase_next           = PH_COUNT;
              end
            end else begin
              phase_next = PH_COUNT;
            end
          end
          PH_LITERAL: begin
            if (lit_room) begin
              pixels_done_next = pd_lit[14:0];
            end
            literal_remaining_next = lit_dec;
            if (lit_last) begin
              if (lit_full) begin
                if (current_channel == CH_EXP) begin
                  phase_next = PH_IDLE;
                end else begin
                  current_channel_next = current_channel + 2'd1;
                  pixels_done_next     = 15'd0;
                  phase_next           = PH_COUNT;
                end
              end else begin
                phase_next = PH_COUNT;
              end
            end
          end
          PH_IDLE: begin
            phase_next = PH_IDLE;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  // Outputs: the fill, if any, caused by this byte
  always_comb begin
    push_req = '0;
    if (in_accept && !scan_start) begin
      unique case (phase)
        PH_SECOND: begin
          if (!is_marker) begin
            push_req.push                    = 1'b1;
            push_req.entry.fill.pixel_index  = 15'd0;
            push_req.entry.fill.channel      = CH_RED;
            push_req.entry.fill.fill_count   = 7'd1;
            push_req.entry.fill.fill_value   = held_first_byte;
            push_req.entry.fill.line_done    = 1'b0;
            push_req.entry.fill.error_code   = ERR_NONE;
            push_req.entry.pair              = 1'b1;
            push_req.entry.second_value      = data_byte;
          end
        end
        PH_RAW: begin
          push_req.push                   = 1'b1;
          push_req.entry.fill.pixel_index = flat_byte_index[16:2];
          push_req.entry.fill.channel     = flat_byte_index[1:0];
          push_req.entry.fill.fill_count  = 7'd1;
          push_req.entry.fill.fill_value  = data_byte;
          push_req.entry.fill.line_done   = raw_done;
          push_req.entry.fill.error_code  = ERR_NONE;
        end
        PH_WLO: begin
          if (width_bad) begin
            push_req.push                  = 1'b1;
            push_req.entry.fill.line_done  = 1'b1;
            push_req.entry.fill.error_code = ERR_WIDTH;
          end
        end
        PH_COUNT: begin
          if (data_byte == 8'd0) begin
            push_req.push                   = 1'b1;
            push_req.entry.fill.pixel_index = pixels_done;
            push_req.entry.fill.channel     = current_channel;
            push_req.entry.fill.line_done   = 1'b1;
            push_req.entry.fill.error_code  = ERR_ZERO;
          end
        end
        PH_RUNVAL: begin
          push_req.push                   = 1'b1;
          push_req.entry.fill.pixel_index = pixels_done;
          push_req.entry.fill.channel     = current_channel;
          push_req.entry.fill.fill_count  = run_cnt;
          push_req.entry.fill.fill_value  = data_byte;
          push_req.entry.fill.line_done   = run_full && (current_channel == CH_EXP);
          push_req.entry.fill.error_code  = ERR_NONE;
        end
        PH_LITERAL: begin
          // drop literal bytes past the width
          if (lit_room) begin
            push_req.push                   = 1'b1;
            push_req.entry.fill.pixel_index = pixels_done;
            push_req.entry.fill.channel     = current_channel;
            push_req.entry.fill.fill_count  = 7'd1;
            push_req.entry.fill.fill_value  = data_byte;
            push_req.entry.fill.line_done   = (pd_lit >= {1'b0, w}) &&
                                              (current_channel == CH_EXP);
            push_req.entry.fill.error_code  = ERR_NONE;
          end
        end
        PH_WHI, PH_IDLE: begin
          push_req.push = 1'b0;
        end
        default: begin
          push_req.push = 1'b0;
        end
      endcase
    end
  end

endmodule

[design/rrd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrd_fifo
// Short queue of fill entries between the parser and the output stage.
// ----------------------------------------------------------------------------
module rrd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rrd_pkg::push_req_t    push_req,
  input  logic                  pop,
  output rrd_pkg::entry_t       head,
  output rrd_pkg::fifo_status_t status
);
  import rrd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;

  assign do_push      = push_req.push && !status.full;
  assign status.full  = count == CW'(DEPTH);
  assign status.empty = count == '0;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_req.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[design/rrd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrd_back
// Output stage: drains the queue into the result register, splitting pairs.
// ----------------------------------------------------------------------------
module rrd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  rrd_pkg::entry_t       head,
  input  rrd_pkg::fifo_status_t status,
  output logic                  pop,
  input  logic                  out_ready,
  output logic                  out_valid,
  output rrd_pkg::fill_t        out_fill
);
  import rrd_pkg::*;

  logic       advance;
  logic       second_pending;
  logic [7:0] second_value;

  assign advance = !out_valid || out_ready;
  assign pop     = advance && !second_pending && !status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      second_pending <= 1'b0;
    end else if (advance) begin
      if (second_pending) begin
        out_valid      <= 1'b1;
        second_pending <= 1'b0;
      end else if (!status.empty) begin
        out_valid      <= 1'b1;
        second_pending <= head.pair;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (second_pending) begin
        // second opening raw byte: pixel 0, green
        out_fill.pixel_index <= 15'd0;
        out_fill.channel     <= CH_GREEN;
        out_fill.fill_count  <= 7'd1;
        out_fill.fill_value  <= second_value;
        out_fill.line_done   <= 1'b0;
        out_fill.error_code  <= ERR_NONE;
      end else if (!status.empty) begin
        out_fill     <= head.fill;
        second_value <= head.second_value;
      end
    end
  end

endmodule

[design/rgbe_rle_scanline_decoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbe_rle_scanline_decoder_core
// Radiance RGBE scanline decoder reporting each write as a pixel fill.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one stream byte per request; s_tuser high marks the
//   first byte of a scanline and abandons any line in progress.
//   m_* channel gives one fill per request: pixel, channel plane, count and
//   value; m_tlast flags the last fill of the line, m_tuser the error code.
//   cfg_* writes the expected scanline width; write it only while the block
//   is idle. cfg_ready is always high.
// Throughput: one byte per cycle while the queue has room. The step that
//   decides raw mode yields two fills in one queue entry, which the output
//   register presents one after the other.
// Path: a fill enters the queue at the edge that accepts its byte, then is
//   loaded from the queue into the output register, which raises
//   m_tvalid.
// Stalls: fills wait in a FIFO_DEPTH entry queue; s_tready drops only when
//   the queue is full, so the parser runs on while m_tready is low.
// Reset: rst clears the parser to idle, empties the queue and sets the
//   width to one pixel. No clearing pass is needed.
// ----------------------------------------------------------------------------
module rgbe_rle_scanline_decoder_core #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] scan_start
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [14:0] pixel_index, [16:15] channel,
                                 // [23:17] fill_count, [31:24] fill_value
  output logic        m_tlast,   // line_done
  output logic [1:0]  m_tuser,   // [1:0] error_code
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_data   // scanline_width
);
  import rrd_pkg::*;

  logic         in_accept;
  push_req_t    push_req;
  entry_t       head;
  fifo_status_t status;
  logic         pop;
  fill_t        out_fill;

  // Accept while the queue has room
  assign s_tready  = !status.full;
  assign in_accept = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  rrd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_accept  (in_accept),
    .data_byte  (s_tdata),
    .scan_start (s_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .push_req   (push_req)
  );

  rrd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push_req (push_req),
    .pop      (pop),
    .head     (head),
    .status   (status)
  );

  rrd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .status    (status),
    .pop       (pop),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_fill  (out_fill)
  );

  // Pack the fill, first field in the lowest bits
  assign m_tdata = {out_fill.fill_value, out_fill.fill_count,
                    out_fill.channel, out_fill.pixel_index};
  assign m_tlast = out_fill.line_done;
  assign m_tuser = out_fill.error_code;

  // An error fill always ends the line and writes nothing
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ERR_NONE)) |-> (m_tlast && (m_tdata[23:17] == 7'd0)
      && (m_tdata[31:24] == 8'd0)))
    else $error("error fill carries data or misses line end");

  // A width mismatch is reported at pixel 0 of the red plane
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == ERR_WIDTH)) |-> ((m_tdata[14:0] == 15'd0)
      && (m_tdata[16:15] == CH_RED)))
    else $error("width mismatch fill at wrong position");

  // The queue never takes a push while full
  assert property (@(posedge clk) disable iff (rst)
    push_req.push |-> !status.full)
    else $error("push into full queue");

endmodule

[tb/sv/rgbe_fill_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbe_fill_checker
// Watches the decoder's byte, fill and width channels, predicts every fill
// from the accepted bytes and compares each fill that leaves the block.
// ----------------------------------------------------------------------------
module rgbe_fill_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic        m_tlast,
  input  logic [1:0]  m_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [14:0] cfg_data,
  output int          fills_pending,
  output int          mismatch_count
);
  import rrd_pkg::*;

  // Predictor state
  logic [14:0] line_width;
  phase_t      phase;
  logic [7:0]  first_byte;
  logic [7:0]  width_hi;
  logic [1:0]  plane;
  logic [14:0] plane_pixels;
  logic [6:0]  run_len;
  logic [7:0]  literal_left;
  logic [16:0] raw_pos;

  fill_t expected_fills[$];
  int    mismatches;

  function automatic int unsigned active_width();
    return (line_width == 15'd0) ? 1 : int'(line_width);
  endfunction

  function automatic void queue_fill(input logic [14:0] pix, input logic [1:0] ch,
                                     input logic [6:0] cnt, input logic [7:0] val,
                                     input logic done, input logic [1:0] err);
    fill_t f;
    f.pixel_index = pix;
    f.channel     = ch;
    f.fill_count  = cnt;
    f.fill_value  = val;
    f.line_done   = done;
    f.error_code  = err;
    expected_fills = {expected_fills, f};
  endfunction

  // Raw byte: position f maps to pixel f/4, channel f%4
  function automatic logic queue_raw(input logic [7:0] val);
    logic done;
    done = (int'(raw_pos) + 1 >= active_width() * 4);
    queue_fill(raw_pos[16:2], raw_pos[1:0], 7'd1, val, done, ERR_NONE);
    raw_pos = raw_pos + 17'd1;
    return done;
  endfunction

  function automatic void close_plane();
    if (plane == CH_EXP) begin
      phase = PH_IDLE;
    end else begin
      plane        = plane + 2'd1;
      plane_pixels = 15'd0;
      phase        = PH_COUNT;
    end
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic start);
    int unsigned w;
    int unsigned room;
    int unsigned cnt;
    logic [14:0] pix;
    logic        done;
    w = active_width();
    if (start) begin
      first_byte = b;
      phase      = PH_SECOND;
      return;
    end
    case (phase)
      PH_SECOND: begin
        if (first_byte == MARKER_BYTE && b == MARKER_BYTE) begin
          phase = PH_WHI;
        end else begin
          raw_pos = 17'd0;
          void'(queue_raw(first_byte));
          phase = queue_raw(b) ? PH_IDLE : PH_RAW;
        end
      end
      PH_RAW: begin
        if (queue_raw(b)) phase = PH_IDLE;
      end
      PH_WHI: begin
        width_hi = b;
        phase    = PH_WLO;
      end
      PH_WLO: begin
        if ({width_hi, b} != w) begin
          queue_fill(15'd0, CH_RED, 7'd0, 8'd0, 1'b1, ERR_WIDTH);
          phase = PH_IDLE;
        end else begin
          plane        = CH_RED;
          plane_pixels = 15'd0;
          phase        = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (b > RUN_FLAG) begin
          run_len = 7'(b - RUN_FLAG);
          phase   = PH_RUNVAL;
        end else if (b == 8'd0) begin
          queue_fill(plane_pixels, plane, 7'd0, 8'd0, 1'b1, ERR_ZERO);
          phase = PH_IDLE;
        end else begin
          literal_left = b;
          phase        = PH_LITERAL;
        end
      end
      PH_RUNVAL: begin
        // clamp the run to what is left of the plane
        room         = w - plane_pixels;
        cnt          = (run_len < room) ? run_len : room;
        pix          = plane_pixels;
        plane_pixels = plane_pixels + 15'(cnt);
        done         = (plane_pixels >= w) && (plane == CH_EXP);
        queue_fill(pix, plane, 7'(cnt), b, done, ERR_NONE);
        if (plane_pixels >= w) close_plane();
        else phase = PH_COUNT;
      end
      PH_LITERAL: begin
        // literal bytes past the width are swallowed without a fill
        if (plane_pixels < w) begin
          pix          = plane_pixels;
          plane_pixels = plane_pixels + 15'd1;
          done         = (plane_pixels >= w) && (plane == CH_EXP);
          queue_fill(pix, plane, 7'd1, b, done, ERR_NONE);
        end
        literal_left = literal_left - 8'd1;
        if (literal_left == 8'd0) begin
          if (plane_pixels >= w) close_plane();
          else phase = PH_COUNT;
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    fill_t want;
    fill_t got;
    if (rst) begin
      line_width   = 15'd1;
      phase        = PH_IDLE;
      first_byte   = 8'd0;
      width_hi     = 8'd0;
      plane        = CH_RED;
      plane_pixels = 15'd0;
      run_len      = 7'd0;
      literal_left = 8'd0;
      raw_pos      = 17'd0;
      mismatches   = 0;
      expected_fills.delete();
    end else begin
      // compare first: a fill never leaves in the cycle its byte arrives
      if (m_tvalid && m_tready) begin
        got.pixel_index = m_tdata[14:0];
        got.channel     = m_tdata[16:15];
        got.fill_count  = m_tdata[23:17];
        got.fill_value  = m_tdata[31:24];
        got.line_done   = m_tlast;
        got.error_code  = m_tuser;
        if (expected_fills.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected fill pix %0d ch %0d cnt %0d val %02h last %0b err %0d",
                     $realtime, got.pixel_index, got.channel, got.fill_count,
                     got.fill_value, got.line_done, got.error_code);
        end else begin
          want = expected_fills.pop_front();
          if (got.pixel_index !== want.pixel_index || got.channel !== want.channel ||
              got.fill_count !== want.fill_count || got.fill_value !== want.fill_value ||
              got.line_done !== want.line_done || got.error_code !== want.error_code) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: fill mismatch", $realtime);
              $display("  expected pix %0d ch %0d cnt %0d val %02h last %0b err %0d",
                       want.pixel_index, want.channel, want.fill_count,
                       want.fill_value, want.line_done, want.error_code);
              $display("  actual   pix %0d ch %0d cnt %0d val %02h last %0b err %0d",
                       got.pixel_index, got.channel, got.fill_count,
                       got.fill_value, got.line_done, got.error_code);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) line_width = cfg_data;
      if (s_tvalid && s_tready) predict_byte(s_tdata, s_tuser);
    end
    fills_pending  <= expected_fills.size();
    mismatch_count <= mismatches;
  end

endmodule

[tb/sv/rgbe_rle_scanline_decoder_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbe_rle_scanline_decoder_core_tb
// Drives encoded scanlines into the decoder and judges the fills it reports.
// A directed opening covers the corner cases, then random lines follow under
// several widths; a separate checker predicts and compares every fill.
// ----------------------------------------------------------------------------
module rgbe_rle_scanline_decoder_core_tb;
  import rrd_pkg::*;

  localparam int RANDOM_BYTES = 400;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 10;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = 8'd0;
  logic        s_tuser   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [14:0] cfg_data  = 15'd0;

  int fills_pending;
  int mismatch_count;

  bit         tx_gaps_on   = 1'b0;
  bit         rx_stalls_on = 1'b0;
  int         rx_hold      = 0;
  int         cycle_count  = 0;
  int         bytes_sent   = 0;
  logic [7:0] line_q[$];

  rgbe_rle_scanline_decoder_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  rgbe_fill_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .m_tuser        (m_tuser),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .fills_pending  (fills_pending),
    .mismatch_count (mismatch_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("rgbe_rle_scanline_decoder_core_tb: FAIL");
      $finish;
    end
  end

  // Fill receiver: hold m_tready low in random bursts when stalls
  // are enabled, otherwise take every fill
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold  <= rx_hold - 1;
      m_tready <= 1'b0;
    end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
      rx_hold  <= $urandom_range(0, 9);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Offer one byte and hold it until the request is taken. An optional gap
  // drops s_tvalid first; valid is left high afterwards so back-to-back
  // bytes need no extra assignment in the same step.
  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    if (tx_gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= start;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Send the first n bytes of the built line; the first one opens the line
  task automatic send_line(input int unsigned n);
    for (int unsigned i = 0; i < n && i < line_q.size(); i++)
      send_byte(line_q[i], i == 0);
  endtask

  // Write the width only once the decoder has nothing left to report
  task automatic write_width(input logic [14:0] w);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (fills_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Append one byte to the line under construction
  function automatic void add_byte(input logic [7:0] b);
    line_q = {line_q, b};
  endfunction

  // Run-length line: header with the matching width, then four planes of
  // runs and literals. Some runs and literals overshoot the plane on purpose;
  // with abort set a zero count may cut the line short.
  function automatic void build_rle_line(input int unsigned w, input bit abort);
    int unsigned rem;
    int unsigned len;
    int          ch;
    logic [1:0]  abort_plane;
    abort_plane = 2'($urandom_range(0, 3));
    line_q = {MARKER_BYTE, MARKER_BYTE, 8'(w >> 8), 8'(w)};
    for (ch = 0; ch < 4; ch++) begin
      rem = w;
      while (rem > 0) begin
        if (abort && ch == abort_plane && $urandom_range(0, 1) == 0) begin
          add_byte(8'd0);
          return;
        end
        if ($urandom_range(0, 1) == 1) begin
          if (rem <= 127 && $urandom_range(0, 7) == 0) len = $urandom_range(rem, 127);
          else len = $urandom_range(1, (rem < 127) ? rem : 127);
          add_byte(RUN_FLAG + 8'(len));
          add_byte(8'($urandom));
        end else begin
          if ($urandom_range(0, 39) == 0) len = 128;
          else if (rem <= 125 && $urandom_range(0, 7) == 0) len = $urandom_range(rem, rem + 3);
          else len = $urandom_range(1, (rem < 128) ? rem : 128);
          add_byte(8'(len));
          repeat (len) add_byte(8'($urandom));
        end
        rem = rem - ((len < rem) ? len : rem);
      end
    end
  endfunction

  // Raw interleaved line: 4*w bytes, never opening with the marker pair
  function automatic void build_raw_line(input int unsigned w);
    logic [7:0] first;
    logic [7:0] second;
    first  = ($urandom_range(0, 3) == 0) ? MARKER_BYTE : 8'($urandom);
    second = 8'($urandom);
    if (first == MARKER_BYTE && second == MARKER_BYTE) second = MARKER_BYTE ^ 8'h01;
    line_q = {first, second};
    repeat (4 * w - 2) add_byte(8'($urandom));
  endfunction

  // Header whose width never matches the configured one
  function automatic void build_bad_header(input int unsigned w);
    int unsigned hdr;
    hdr = $urandom_range(0, 65535);
    if (hdr == w) hdr = hdr ^ 1;
    line_q = {MARKER_BYTE, MARKER_BYTE, 8'(hdr >> 8), 8'(hdr)};
  endfunction

  // One random line; clean lines always run to completion so the decoder
  // ends idle
  task automatic random_line(input int unsigned w, input bit clean);
    int kind;
    kind = clean ? $urandom_range(0, 69) : $urandom_range(0, 99);
    // stray bytes between lines
    if (!clean && $urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
    if (kind < 50) begin
      build_rle_line(w, 1'b0);
      send_line(line_q.size());
    end else if (kind < 70) begin
      build_raw_line(w);
      send_line(line_q.size());
    end else if (kind < 78) begin
      build_bad_header(w);
      send_line(line_q.size());
    end else if (kind < 88) begin
      build_rle_line(w, 1'b1);
      send_line(line_q.size());
    end else begin
      // abandon a line part way; the next opening byte restarts the parser
      if ($urandom_range(0, 1) == 1) build_rle_line(w, 1'b0);
      else build_raw_line(w);
      send_line($urandom_range(1, line_q.size() - 1));
    end
  endtask

  initial begin
    int unsigned widths[8];
    int unsigned w;
    int          phase_start;
    int          per_phase;
    widths    = '{3, 1, 6, 2, 8, 4, 5, 7};
    per_phase = RANDOM_BYTES / 8;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset width of one pixel
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    send_byte(8'hFF, 1'b0);                        // stray byte while idle
    line_q = {MARKER_BYTE, 8'hFD, 8'h00, 8'h80};   // raw, held byte is a marker
    send_line(line_q.size());
    // run clamped to the width, literal overflow, shortest run, last literal
    line_q = {MARKER_BYTE, MARKER_BYTE, 8'h00, 8'h01,
              RUN_FLAG + 8'd127, 8'hAA,
              8'd2, 8'h11, 8'h22,
              RUN_FLAG + 8'd1, 8'h00,
              8'd1, 8'hFF};
    send_line(line_q.size());
    line_q = {MARKER_BYTE, MARKER_BYTE, 8'h00};    // abandoned by a restart
    send_line(line_q.size());
    line_q = {MARKER_BYTE, MARKER_BYTE, 8'h00, 8'h09};  // width mismatch
    send_line(line_q.size());
    line_q = {MARKER_BYTE, MARKER_BYTE, 8'h00, 8'h01, 8'd0};  // zero count
    send_line(line_q.size());

    // Zero width behaves as one pixel
    write_width(15'd0);
    line_q = {8'h7F, 8'h01, 8'hFE, 8'h40};
    send_line(line_q.size());
    line_q = {MARKER_BYTE, MARKER_BYTE, 8'h00, 8'h01,
              RUN_FLAG + 8'd5, 8'h01, RUN_FLAG + 8'd1, 8'h02,
              8'd1, 8'h03, RUN_FLAG + 8'd64, 8'h04};
    send_line(line_q.size());

    // Widest line: fill the red plane with full runs, the last one clamped
    // to a single pixel, then abort on a zero count in green
    write_width(15'h7FFF);
    line_q = {MARKER_BYTE, MARKER_BYTE, 8'h7F, 8'hFF};
    repeat (259) begin
      add_byte(RUN_FLAG + 8'd127);
      add_byte(8'($urandom));
    end
    add_byte(8'd0);
    send_line(line_q.size());
    line_q = {MARKER_BYTE, MARKER_BYTE, 8'h7F, 8'hFE};
    send_line(line_q.size());

    // Random lines under several widths; the last phase runs without gaps
    for (int p = 0; p < 8; p++) begin
      write_width(15'(widths[p]));
      w           = widths[p];
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < per_phase) begin
        if (p == 7) begin
          tx_gaps_on   = 1'b0;
          rx_stalls_on = 1'b0;
        end else begin
          tx_gaps_on   = ($urandom_range(0, 3) != 0);
          rx_stalls_on = ($urandom_range(0, 3) != 0);
        end
        random_line(w, 1'b0);
      end
      random_line(w, 1'b1);
    end

    // Drain and judge
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (fills_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && fills_pending == 0) begin
      $display("rgbe_rle_scanline_decoder_core_tb: PASS");
    end else begin
      $display("rgbe_rle_scanline_decoder_core_tb: FAIL");
    end
    $finish;
  end

endmodule
